// ----- hw/rtl/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants of the beat delay queue with RR statistics.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

    // Queue and history sizes
    localparam int BEAT_DEPTH          = 16;
    localparam int INTERVAL_DEPTH_LOG2 = 3;
    localparam int INTERVAL_DEPTH      = 2 ** INTERVAL_DEPTH_LOG2;
    localparam int DEFAULT_INTERVAL    = 300;

    // Derived widths
    localparam int BEAT_AW   = $clog2(BEAT_DEPTH);
    localparam int COUNT_W   = $clog2(BEAT_DEPTH + 1);
    localparam int IV_AW     = INTERVAL_DEPTH_LOG2;
    localparam int VAR_CNT_W = IV_AW + 1;
    localparam int SUM_W     = 16 + INTERVAL_DEPTH_LOG2;
    localparam int ACC_W     = 32 + INTERVAL_DEPTH_LOG2;

    // Fixed field widths
    localparam int MODE_W        = 2;
    localparam int DELAY_W       = 15;
    localparam int STATUS_W      = 2;
    localparam int AGE_W         = 16;
    localparam int BEAT_COUNT_W  = 5;
    localparam int VAR_W         = 32;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [DELAY_W-1:0] beat_delay;
    } bdq_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [AGE_W-1:0]        popped_delay;
        logic [BEAT_COUNT_W-1:0] beat_count;
        logic [AGE_W-1:0]        oldest_delay;
        logic [AGE_W-1:0]        post_interval;
        logic [AGE_W-1:0]        pre_interval;
        logic [AGE_W-1:0]        mean_interval;
        logic [VAR_W-1:0]        var_interval;
    } bdq_out_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bdq_ram.sv -----
// ----------------------------------------------------------------------------
// bdq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/beat_delay_queue_rr_stats.sv -----
// An accepted item passes through S_OP, S_MOD, S_OLD and the variance pass S_VAR
// to S_DONE, which registers the result and holds while an earlier result waits.
// A new item is taken only back in S_IDLE, after the variance pass, which reads
// every stored interval through the single read port of its RAM.
// Reset: synchronous, active low; afterwards a clearing pass writes the default
// interval into every entry of the history RAM before s_ready rises.
// ----------------------------------------------------------------------------
// beat_delay_queue_rr_stats
// FIFO of beat ages and a history of RR intervals with mean and variance.
// Ages are kept as time stamps against a count of tick operations, so a tick
// needs no walk over the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module beat_delay_queue_rr_stats
    import bdq_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire bdq_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output bdq_out_t      m_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_OP,
        S_MOD,
        S_OLD,
        S_VAR,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [MODE_W-1:0]      mode_reg;
    logic [DELAY_W-1:0]     delay_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [AGE_W-1:0]       popped_reg;
    logic [AGE_W-1:0]       oldest_reg;
    logic [AGE_W-1:0]       tick_reg;
    logic [BEAT_AW-1:0]     head_reg;
    logic [BEAT_AW-1:0]     tail_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [IV_AW-1:0]       iv_ptr_reg;
    logic [IV_AW-1:0]       clr_cnt_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [AGE_W-1:0]       post_reg;
    logic [AGE_W-1:0]       pre_reg;
    logic [AGE_W-1:0]       mean_reg;
    logic [VAR_CNT_W-1:0]   var_cnt_reg;
    logic                   p1_reg;
    logic                   p2_reg;
    logic                   p3_reg;
    logic [AGE_W-1:0]       dev_reg;
    logic [31:0]            sq_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic                   m_valid_reg;
    bdq_out_t               m_data_reg;

    // RAM ports
    logic                   beat_we;
    logic [BEAT_AW-1:0]     beat_waddr;
    logic [AGE_W-1:0]       beat_wdata;
    logic [BEAT_AW-1:0]     beat_raddr;
    logic [AGE_W-1:0]       beat_rdata;
    logic                   iv_we;
    logic [IV_AW-1:0]       iv_waddr;
    logic [AGE_W-1:0]       iv_wdata;
    logic [IV_AW-1:0]       iv_raddr;
    logic [AGE_W-1:0]       iv_rdata;

    // Decoded operation
    logic                   q_empty;
    logic                   q_full;
    logic                   do_add;
    logic                   do_shift;
    logic                   do_pop;
    logic [BEAT_AW-1:0]     newest_idx;
    logic [BEAT_AW-1:0]     head_inc;
    logic [BEAT_AW-1:0]     tail_inc;
    logic [AGE_W-1:0]       new_iv;
    logic                   var_issue;
    logic [AGE_W-1:0]       dev_next;

    assign q_empty  = (count_reg == '0);
    assign q_full   = (count_reg == COUNT_W'(BEAT_DEPTH));
    assign do_add   = (mode_reg == MODE_ADD) && !q_full;
    assign do_shift = do_add && !q_empty;
    assign do_pop   = (mode_reg == MODE_POP) && !q_empty;

    assign newest_idx = (tail_reg == '0) ? BEAT_AW'(BEAT_DEPTH - 1) : tail_reg - 1'b1;
    assign head_inc   = (head_reg == BEAT_AW'(BEAT_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc   = (tail_reg == BEAT_AW'(BEAT_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    // Newest age minus the new delay, modulo 2^16
    assign new_iv = tick_reg - beat_rdata - AGE_W'(delay_reg);

    assign var_issue = (state_reg == S_VAR) && (var_cnt_reg != VAR_CNT_W'(INTERVAL_DEPTH));
    assign dev_next  = (iv_rdata >= mean_reg) ? iv_rdata - mean_reg : mean_reg - iv_rdata;

    // Beat RAM addressing
    always_comb begin
        beat_raddr = head_reg;
        if (state_reg == S_OP && mode_reg == MODE_ADD) begin
            beat_raddr = newest_idx;
        end
        beat_we    = (state_reg == S_MOD) && do_add;
        beat_waddr = tail_reg;
        beat_wdata = tick_reg - AGE_W'(delay_reg);
    end

    // Interval RAM addressing
    always_comb begin
        iv_raddr = (state_reg == S_VAR) ? var_cnt_reg[IV_AW-1:0] : iv_ptr_reg;
        if (state_reg == S_CLEAR) begin
            iv_we    = 1'b1;
            iv_waddr = clr_cnt_reg;
            iv_wdata = AGE_W'(DEFAULT_INTERVAL);
        end else begin
            iv_we    = (state_reg == S_MOD) && do_shift;
            iv_waddr = iv_ptr_reg;
            iv_wdata = new_iv;
        end
    end

    bdq_ram #(
        .WIDTH (AGE_W),
        .DEPTH (BEAT_DEPTH)
    ) u_beat_ram (
        .aclk  (aclk),
        .we    (beat_we),
        .waddr (beat_waddr),
        .wdata (beat_wdata),
        .raddr (beat_raddr),
        .rdata (beat_rdata)
    );

    bdq_ram #(
        .WIDTH (AGE_W),
        .DEPTH (INTERVAL_DEPTH)
    ) u_iv_ram (
        .aclk  (aclk),
        .we    (iv_we),
        .waddr (iv_waddr),
        .wdata (iv_wdata),
        .raddr (iv_raddr),
        .rdata (iv_rdata)
    );

    // Sequencer, queue state and registered result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            tick_reg    <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            iv_ptr_reg  <= '0;
            sum_reg     <= SUM_W'(DEFAULT_INTERVAL * INTERVAL_DEPTH);
            post_reg    <= AGE_W'(DEFAULT_INTERVAL);
            pre_reg     <= AGE_W'(DEFAULT_INTERVAL);
            var_cnt_reg <= '0;
            p1_reg      <= 1'b0;
            p2_reg      <= 1'b0;
            p3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // Release the result once taken; S_DONE reloads it on its own
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == IV_AW'(INTERVAL_DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        mode_reg  <= s_data.mode;
                        delay_reg <= s_data.beat_delay;
                        state_reg <= S_OP;
                    end
                end
                S_OP: begin
                    state_reg <= S_MOD;
                end
                S_MOD: begin
                    // Report the outcome of the operation
                    if (mode_reg == MODE_ADD && q_full) begin
                        status_reg <= STATUS_FULL;
                    end else if (mode_reg == MODE_POP && q_empty) begin
                        status_reg <= STATUS_EMPTY;
                    end else begin
                        status_reg <= STATUS_DONE;
                    end
                    popped_reg <= do_pop ? tick_reg - beat_rdata : '0;
                    if (mode_reg == MODE_TICK) begin
                        tick_reg <= tick_reg + 1'b1;
                    end
                    // Append the beat and shift in its interval
                    if (do_add) begin
                        tail_reg  <= tail_inc;
                        count_reg <= count_reg + 1'b1;
                    end
                    if (do_shift) begin
                        sum_reg    <= sum_reg - SUM_W'(iv_rdata) + SUM_W'(new_iv);
                        post_reg   <= new_iv;
                        pre_reg    <= post_reg;
                        iv_ptr_reg <= iv_ptr_reg + 1'b1;
                    end
                    // Drop the oldest beat
                    if (do_pop) begin
                        head_reg   <= head_inc;
                        count_reg  <= count_reg - 1'b1;
                    end
                    state_reg <= S_OLD;
                end
                S_OLD: begin
                    // Mean of D 16-bit values never exceeds 16 bits
                    mean_reg    <= sum_reg[SUM_W-1:INTERVAL_DEPTH_LOG2];
                    var_cnt_reg <= '0;
                    acc_reg     <= '0;
                    p1_reg      <= 1'b0;
                    p2_reg      <= 1'b0;
                    p3_reg      <= 1'b0;
                    state_reg   <= S_VAR;
                end
                S_VAR: begin
                    // Head read issued in S_OLD lands on the first pass cycle
                    if (var_cnt_reg == '0) begin
                        oldest_reg <= q_empty ? '0 : tick_reg - beat_rdata;
                    end
                    if (var_issue) begin
                        var_cnt_reg <= var_cnt_reg + 1'b1;
                    end
                    p1_reg <= var_issue;
                    p2_reg <= p1_reg;
                    p3_reg <= p2_reg;
                    if (p1_reg) begin
                        dev_reg <= dev_next;
                    end
                    if (p2_reg) begin
                        sq_reg <= dev_reg * dev_reg;
                    end
                    if (p3_reg) begin
                        acc_reg <= acc_reg + ACC_W'(sq_reg);
                    end
                    if (!var_issue && !p1_reg && !p2_reg && !p3_reg) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.status          <= status_reg;
                        m_data_reg.popped_delay    <= popped_reg;
                        m_data_reg.beat_count      <= BEAT_COUNT_W'(count_reg);
                        m_data_reg.oldest_delay    <= oldest_reg;
                        m_data_reg.post_interval   <= post_reg;
                        m_data_reg.pre_interval    <= pre_reg;
                        m_data_reg.mean_interval   <= mean_reg;
                        m_data_reg.var_interval    <= acc_reg[ACC_W-1:INTERVAL_DEPTH_LOG2];
                        state_reg                  <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bdq_checker.sv -----
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks of the beat delay queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_checker
    import bdq_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire bdq_in_t  s_data,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire bdq_out_t m_data
);

    // A stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // A waiting input item holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input item changed while waiting");

    // Ignored pop leaves an empty queue and no popped age
    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_EMPTY |->
            m_data.beat_count == '0 && m_data.popped_delay == '0)
        else $error("empty pop reported a beat");

    // Dropped beat only on a full queue
    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_FULL |->
            m_data.beat_count == BEAT_COUNT_W'(BEAT_DEPTH))
        else $error("beat dropped while queue not full");

    // Empty queue reports no oldest age
    a_empty_oldest: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.beat_count == '0 |-> m_data.oldest_delay == '0)
        else $error("oldest age reported on empty queue");

endmodule

bind beat_delay_queue_rr_stats bdq_checker u_bdq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ----- tb/sv/beat_delay_queue_rr_stats_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// beat_delay_queue_rr_stats_tb
// Self-checking bench for the beat delay queue with RR interval statistics.
// A behavioural copy of the queue and interval history predicts every result.
// Stimulus runs as a short directed sequence, then a tick run on a full
// queue, then random fill and drain sequences. In some phases the sender idles
// in bursts and the receiver stalls on a rotating pattern.
// ----------------------------------------------------------------------------
module beat_delay_queue_rr_stats_tb;
    import bdq_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int LATENCY       = INTERVAL_DEPTH + 8;
    localparam int QUIET_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int RANDOM_PHASES = 4;
    localparam int AGE_TICKS     = 300;
    localparam int MAX_REPORTS   = 100;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    bdq_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    bdq_out_t m_data;

    // Shadow copy of the beat queue and interval history
    logic [AGE_W-1:0] shadow_age [BEAT_DEPTH];
    int unsigned      shadow_count;
    logic [AGE_W-1:0] shadow_rr [INTERVAL_DEPTH];

    bdq_in_t     pending_beats [$];
    bdq_out_t    expected_reports [$];
    int unsigned n_queued;
    int unsigned n_accepted;
    int unsigned n_checked;
    int unsigned n_errors;
    int unsigned n_reports;
    int unsigned n_full;
    int unsigned n_empty;
    int unsigned quiet_cycles;
    bit          in_taken;
    bit          gaps_on;
    bit          stalls_on;
    int unsigned gap_left;
    int unsigned burst_left;
    int unsigned stall_left;
    logic [7:0]  stall_pattern;

    beat_delay_queue_rr_stats u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one item to the shadow state and build the result it should give
    function automatic bdq_out_t step_beat_queue(input bdq_in_t item);
        bdq_out_t        rep;
        longint unsigned rr_sum;
        longint unsigned rr_mean;
        longint unsigned spread;
        longint unsigned sq_sum;
        int              i;
        rep = '0;
        rep.status = STATUS_DONE;
        case (item.mode)
            MODE_TICK: begin
                for (i = 0; i < shadow_count; i++)
                    shadow_age[i] = shadow_age[i] + 1'b1;
            end
            MODE_ADD: begin
                if (shadow_count >= BEAT_DEPTH) begin
                    rep.status = STATUS_FULL;
                end else begin
                    // newest stored age minus the new one, kept modulo 2^16
                    if (shadow_count > 0) begin
                        for (i = INTERVAL_DEPTH - 1; i > 0; i--)
                            shadow_rr[i] = shadow_rr[i-1];
                        shadow_rr[0] = shadow_age[shadow_count-1] - AGE_W'(item.beat_delay);
                    end
                    shadow_age[shadow_count] = AGE_W'(item.beat_delay);
                    shadow_count++;
                end
            end
            MODE_POP: begin
                if (shadow_count == 0) begin
                    rep.status = STATUS_EMPTY;
                end else begin
                    rep.popped_delay = shadow_age[0];
                    for (i = 1; i < shadow_count; i++)
                        shadow_age[i-1] = shadow_age[i];
                    shadow_count--;
                end
            end
            default: begin
            end
        endcase

        rr_sum = 0;
        for (i = 0; i < INTERVAL_DEPTH; i++)
            rr_sum += shadow_rr[i];
        rr_mean = rr_sum >> INTERVAL_DEPTH_LOG2;
        if (rr_mean > 64'd65535)
            rr_mean = 64'd65535;
        sq_sum = 0;
        for (i = 0; i < INTERVAL_DEPTH; i++) begin
            spread = (shadow_rr[i] >= rr_mean) ? shadow_rr[i] - rr_mean : rr_mean - shadow_rr[i];
            sq_sum += spread * spread;
        end
        sq_sum = sq_sum >> INTERVAL_DEPTH_LOG2;
        if (sq_sum > 64'hFFFF_FFFF)
            sq_sum = 64'hFFFF_FFFF;

        rep.beat_count    = BEAT_COUNT_W'(shadow_count);
        rep.oldest_delay  = (shadow_count > 0) ? shadow_age[0] : '0;
        rep.post_interval = shadow_rr[0];
        rep.pre_interval  = shadow_rr[1];
        rep.mean_interval = AGE_W'(rr_mean);
        rep.var_interval  = VAR_W'(sq_sum);
        return rep;
    endfunction

    task automatic check_field(input string field, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            n_errors++;
            if (n_reports < MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            n_reports++;
        end
    endtask

    task automatic queue_item(input logic [MODE_W-1:0] mode, input logic [DELAY_W-1:0] delay);
        bdq_in_t it;
        it.mode       = mode;
        it.beat_delay = delay;
        pending_beats.push_back(it);
        n_queued++;
    endtask

    // Fill and drain segments so the queue swings between empty and full
    task automatic queue_random(input int unsigned count);
        int unsigned seg_left;
        bit          filling;
        int unsigned roll;
        int unsigned add_share;
        int unsigned spread_roll;
        logic [DELAY_W-1:0] delay;
        seg_left = 0;
        filling  = 1'b1;
        repeat (count) begin
            if (seg_left == 0) begin
                filling  = $urandom_range(0, 1);
                seg_left = $urandom_range(10, 60);
            end
            seg_left--;
            spread_roll = $urandom_range(0, 9);
            if (spread_roll < 7)
                delay = DELAY_W'($urandom_range(0, 255));
            else if (spread_roll < 9)
                delay = DELAY_W'($urandom_range(0, 4095));
            else
                delay = DELAY_W'($urandom);
            add_share = filling ? 48 : 12;
            roll = $urandom_range(0, 99);
            if (roll < 4)
                queue_item(MODE_UNUSED, delay);
            else if (roll < 39)
                queue_item(MODE_TICK, delay);
            else if (roll < 39 + add_share)
                queue_item(MODE_ADD, delay);
            else
                queue_item(MODE_POP, delay);
        end
    endtask

    // Hold until every queued item is taken and every result has come back
    task automatic wait_drained();
        while (n_accepted != n_queued || expected_reports.size() != 0)
            @(negedge aclk);
    endtask

    // Sample both channels: predict accepted items, check accepted results
    always @(posedge aclk) begin : monitor
        bdq_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = step_beat_queue(s_data);
                if (want.status == STATUS_FULL)
                    n_full++;
                if (want.status == STATUS_EMPTY)
                    n_empty++;
                expected_reports.push_back(want);
                n_accepted++;
                in_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    n_errors++;
                    if (n_reports < MAX_REPORTS)
                        $display("%0t ns: unexpected result, expected none, actual %h",
                                 $time, m_data);
                    n_reports++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("status", want.status, m_data.status);
                    check_field("popped_delay", want.popped_delay, m_data.popped_delay);
                    check_field("beat_count", want.beat_count, m_data.beat_count);
                    check_field("oldest_delay", want.oldest_delay, m_data.oldest_delay);
                    check_field("post_interval", want.post_interval, m_data.post_interval);
                    check_field("pre_interval", want.pre_interval, m_data.pre_interval);
                    check_field("mean_interval", want.mean_interval, m_data.mean_interval);
                    check_field("var_interval", want.var_interval, m_data.var_interval);
                    n_checked++;
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Drive items in bursts with random gaps while gaps are on; hold each one until taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            in_taken = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
                s_data  <= pending_beats.pop_front();
                s_valid <= 1'b1;
                if (burst_left != 0)
                    burst_left--;
                if (burst_left == 0 && gaps_on) begin
                    gap_left   = $urandom_range(1, 20);
                    burst_left = $urandom_range(1, 12);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Stall the result channel on a rotating pattern, reloaded now and then
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_pattern = 8'($urandom) | (8'd1 << $urandom_range(0, 7));
            stall_left    = $urandom_range(16, 64);
        end
        stall_left--;
        stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
        m_ready <= !stalls_on || stall_pattern[0];
    end

    // Give up when no handshake has happened for too long
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t ns: no handshake for %0d cycles", $time, quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int i;
        for (i = 0; i < BEAT_DEPTH; i++)
            shadow_age[i] = '0;
        for (i = 0; i < INTERVAL_DEPTH; i++)
            shadow_rr[i] = AGE_W'(DEFAULT_INTERVAL);
        shadow_count = 0;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty queue, unused mode, first beat, negative interval
        queue_item(MODE_POP, '0);
        queue_item(MODE_UNUSED, 15'h7FFF);
        queue_item(MODE_TICK, 15'h7FFF);
        queue_item(MODE_ADD, '0);
        queue_item(MODE_ADD, 15'h7FFF);
        queue_item(MODE_TICK, '0);
        queue_item(MODE_POP, 15'h7FFF);
        queue_item(MODE_POP, '0);
        queue_item(MODE_POP, '0);
        // fill to the top, then one more beat that must be dropped
        for (i = 0; i < BEAT_DEPTH; i++)
            queue_item(MODE_ADD, 15'h7FFF >> i);
        queue_item(MODE_ADD, 15'h2AAA);
        wait_drained();

        // Tick a full queue back to back, then pop and refill
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        repeat (AGE_TICKS) queue_item(MODE_TICK, DELAY_W'($urandom));
        queue_item(MODE_POP, '0);
        queue_item(MODE_ADD, 15'h7FFF);
        wait_drained();

        // Random phases with each mix of sender and receiver idling
        for (i = 0; i < RANDOM_PHASES; i++) begin
            gaps_on   = (i == 0) || (i == 2);
            stalls_on = (i == 0) || (i == 3);
            queue_random(RANDOM_ITEMS / RANDOM_PHASES);
            wait_drained();
        end

        repeat (2 * LATENCY) @(posedge aclk);
        $display("Accepted %0d items (%0d in the full-queue tick run), checked %0d results.",
                 n_accepted, AGE_TICKS, n_checked);
        $display("Dropped %0d beats on a full queue, ignored %0d pops on an empty queue.",
                 n_full, n_empty);
        if (n_errors == 0 && expected_reports.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results outstanding", n_errors,
                     expected_reports.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
